// File: hdl/rtnh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtnh_pkg: shared types and constants for the ray/triangle hit block
// Field widths, register indexes, controller/datapath command and status.
// ----------------------------------------------------------------------------
package rtnh_pkg;
  localparam int FRAC_BITS = 16;
  localparam int UV_BITS = 16;
  localparam int EPS_SHIFT = 3 * FRAC_BITS - 17;
  localparam int DW = 128;

  localparam logic [2:0] REG_ORG_X = 3'd0;
  localparam logic [2:0] REG_ORG_Y = 3'd1;
  localparam logic [2:0] REG_ORG_Z = 3'd2;
  localparam logic [2:0] REG_DIR_X = 3'd3;
  localparam logic [2:0] REG_DIR_Y = 3'd4;
  localparam logic [2:0] REG_DIR_Z = 3'd5;
  localparam logic [2:0] REG_RANGE = 3'd6;
  localparam logic [2:0] REG_MODE = 3'd7;

  // datapath micro-operations
  localparam logic [3:0] OP_NONE = 4'd0;
  localparam logic [3:0] OP_LOAD = 4'd1;  // capture item, form edges
  localparam logic [3:0] OP_MUL = 4'd2;   // one product into accumulator
  localparam logic [3:0] OP_STORE = 4'd3; // last product; sum into p/q slot or det/u/v/t
  localparam logic [3:0] OP_FOLD = 4'd4;  // sign fold and tests
  localparam logic [3:0] OP_DIV_T = 4'd5;
  localparam logic [3:0] OP_DIV_U = 4'd6;
  localparam logic [3:0] OP_DIV_V = 4'd7;
  localparam logic [3:0] OP_DSTEP = 4'd8; // one divider bit
  localparam logic [3:0] OP_DDONE = 4'd9; // latch quotient, check range
  localparam logic [3:0] OP_FINISH = 4'd10;

  typedef struct packed {
    logic [3:0] op;
    logic [4:0] sel;   // program step for OP_MUL/OP_STORE
    logic       first; // clear accumulator on this product
    logic       sub;   // subtract product
    logic       half;  // upper half of a wide operand, weighted by 2^33
  } rtnh_cmd_t;

  typedef struct packed {
    logic pass;  // geometric tests passed
    logic inrng; // quotient in range after OP_DDONE
    logic dbusy; // divider still iterating
  } rtnh_sts_t;
endpackage
`default_nettype wire

// File: hdl/rtnh_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtnh_if: valid/ready channels for triangles, results and register writes
// ----------------------------------------------------------------------------
interface rtnh_tri_if;
  logic        valid;
  logic        ready;
  logic [31:0] vert0_x, vert0_y, vert0_z;
  logic [31:0] vert1_x, vert1_y, vert1_z;
  logic [31:0] vert2_x, vert2_y, vert2_z;
  logic [31:0] tri_id;
  logic        new_query;
  modport source(output valid, vert0_x, vert0_y, vert0_z, vert1_x, vert1_y, vert1_z,
                 vert2_x, vert2_y, vert2_z, tri_id, new_query, input ready);
  modport sink(input valid, vert0_x, vert0_y, vert0_z, vert1_x, vert1_y, vert1_z,
               vert2_x, vert2_y, vert2_z, tri_id, new_query, output ready);
endinterface

interface rtnh_res_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [30:0] hit_distance;
  logic [16:0] u_coord;
  logic [16:0] v_coord;
  logic [31:0] hit_id;
  logic        new_nearest;
  modport source(output valid, hit, hit_distance, u_coord, v_coord, hit_id, new_nearest,
                 input ready);
  modport sink(input valid, hit, hit_distance, u_coord, v_coord, hit_id, new_nearest,
               output ready);
endinterface

interface rtnh_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: hdl/rtnh_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtnh_ctrl: sequencer for the hit test
// Steps the product program; on a pass divides t, then u and v if in range.
// ----------------------------------------------------------------------------
module rtnh_ctrl (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire                     out_ready,
  input  rtnh_pkg::rtnh_sts_t     sts,
  output rtnh_pkg::rtnh_cmd_t     cmd
);
  import rtnh_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PROG = 4'd1;
  localparam logic [3:0] S_FOLD = 4'd2;
  localparam logic [3:0] S_DT = 4'd3;
  localparam logic [3:0] S_DTW = 4'd4;
  localparam logic [3:0] S_DTC = 4'd5;
  localparam logic [3:0] S_DU = 4'd6;
  localparam logic [3:0] S_DUW = 4'd7;
  localparam logic [3:0] S_DV = 4'd8;
  localparam logic [3:0] S_DVW = 4'd9;
  localparam logic [3:0] S_FIN = 4'd10;
  localparam logic [3:0] S_OUT = 4'd11;
  localparam logic [4:0] PROG_LAST = 5'd23;

  logic [3:0] state, state_next;
  logic [4:0] pc, pc_next;
  logic       half, half_next;

  // product program: step -> flags; see datapath for operands
  function automatic logic [3:0] prog_flags(input logic [4:0] p);
    // {wide, store_after, first, sub}; wide steps go through in two halves
    case (p)
      5'd0, 5'd2, 5'd4, 5'd12, 5'd14, 5'd16: prog_flags = 4'b0010;
      5'd1, 5'd3, 5'd5, 5'd13, 5'd15, 5'd17: prog_flags = 4'b0101;
      5'd6, 5'd9, 5'd18, 5'd21: prog_flags = 4'b1010;
      5'd7, 5'd10, 5'd19, 5'd22: prog_flags = 4'b1000;
      5'd8, 5'd11, 5'd20, 5'd23: prog_flags = 4'b1100;
      default: prog_flags = 4'b0000;
    endcase
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pc <= '0;
      half <= 1'b0;
    end else begin
      state <= state_next;
      pc <= pc_next;
      half <= half_next;
    end
  end

  always_comb begin
    logic [3:0] f;
    f = prog_flags(pc);
    state_next = state;
    pc_next = pc;
    half_next = half;
    cmd = '{op: OP_NONE, sel: pc, first: 1'b0, sub: 1'b0, half: 1'b0};
    in_ready = (state == S_IDLE);
    out_valid = (state == S_OUT);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = OP_LOAD;
          state_next = S_PROG;
          pc_next = '0;
          half_next = 1'b0;
        end
      end
      S_PROG: begin
        cmd.op = OP_MUL;
        cmd.half = half;
        cmd.first = f[1] && !half;
        cmd.sub = f[0];
        if (f[2] && (!f[3] || half)) begin
          cmd.op = OP_STORE;
        end
        if (f[3] && !half) begin
          half_next = 1'b1;
        end else begin
          half_next = 1'b0;
          if (pc == PROG_LAST) begin
            state_next = S_FOLD;
          end else begin
            pc_next = pc + 5'd1;
          end
        end
      end
      S_FOLD: begin
        cmd.op = OP_FOLD;
        state_next = S_DT;
      end
      S_DT: begin
        if (sts.pass) begin
          cmd.op = OP_DIV_T;
          state_next = S_DTW;
        end else begin
          state_next = S_FIN;
        end
      end
      S_DTW: begin
        cmd.op = OP_DSTEP;
        if (!sts.dbusy) state_next = S_DTC;
      end
      S_DTC: begin
        cmd.op = OP_DDONE;
        state_next = S_DU;
      end
      S_DU: begin
        if (sts.inrng) begin
          cmd.op = OP_DIV_U;
          state_next = S_DUW;
        end else begin
          state_next = S_FIN;
        end
      end
      S_DUW: begin
        cmd.op = OP_DSTEP;
        if (!sts.dbusy) state_next = S_DV;
      end
      S_DV: begin
        cmd.op = OP_DIV_V;
        state_next = S_DVW;
      end
      S_DVW: begin
        cmd.op = OP_DSTEP;
        if (!sts.dbusy) state_next = S_FIN;
      end
      S_FIN: begin
        cmd.op = OP_FINISH;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// File: hdl/rtnh_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtnh_dpath: shared multiplier, accumulator, tests and restoring divider
// Holds ray registers, nearest record and the result word.
// ----------------------------------------------------------------------------
module rtnh_dpath (
  input  wire                  clk,
  input  wire                  rst,
  input  rtnh_pkg::rtnh_cmd_t  cmd,
  output rtnh_pkg::rtnh_sts_t  sts,
  input  wire                  cfg_we,
  input  wire [2:0]            cfg_index,
  input  wire [31:0]           cfg_data,
  input  wire [32*9-1:0]       verts,
  input  wire [31:0]           tri_id,
  input  wire                  new_query,
  output logic                 hit,
  output logic [30:0]          hit_distance,
  output logic [16:0]          u_coord,
  output logic [16:0]          v_coord,
  output logic [31:0]          hit_id,
  output logic                 new_nearest
);
  import rtnh_pkg::*;

  logic signed [31:0] org [3];
  logic signed [31:0] dir [3];
  logic [30:0] max_range;
  logic [1:0]  mode_bits;
  logic [30:0] best_distance;
  logic        have_hit;

  // ev: 0..2 e1, 3..5 e2, 6..8 s, 9..11 d (33-bit); pq: 0..2 p, 3..5 q (66-bit)
  logic signed [32:0] ev [12];
  logic signed [65:0] pq [6];
  logic signed [DW-1:0] det, uu, vv, tt;
  logic signed [DW-1:0] acc;
  logic signed [33:0] ma;
  logic signed [66:0] prod;
  logic signed [DW-1:0] term;
  logic        pass;
  logic [30:0] limit;

  // divider
  logic [DW-1:0] dnum, dden, drem, dquo;
  logic [7:0]  dcnt;
  logic [30:0] tdist;
  logic        inrng;

  // operand selection per program step
  logic signed [65:0] opa;
  logic signed [32:0] opb;
  logic [4:0] dst;
  logic       wide;

  always_comb begin
    opa = '0;
    opb = '0;
    dst = 5'd31;
    wide = 1'b0;
    case (cmd.sel)
      // p = d x e2
      5'd0: begin opa = 66'(ev[10]); opb = ev[5]; end
      5'd1: begin opa = 66'(ev[11]); opb = ev[4]; dst = 5'd0; end
      5'd2: begin opa = 66'(ev[11]); opb = ev[3]; end
      5'd3: begin opa = 66'(ev[9]);  opb = ev[5]; dst = 5'd1; end
      5'd4: begin opa = 66'(ev[9]);  opb = ev[4]; end
      5'd5: begin opa = 66'(ev[10]); opb = ev[3]; dst = 5'd2; end
      // det = e1.p, u = s.p
      5'd6:  begin opa = pq[0]; opb = ev[0]; wide = 1'b1; end
      5'd7:  begin opa = pq[1]; opb = ev[1]; wide = 1'b1; end
      5'd8:  begin opa = pq[2]; opb = ev[2]; wide = 1'b1; dst = 5'd6; end
      5'd9:  begin opa = pq[0]; opb = ev[6]; wide = 1'b1; end
      5'd10: begin opa = pq[1]; opb = ev[7]; wide = 1'b1; end
      5'd11: begin opa = pq[2]; opb = ev[8]; wide = 1'b1; dst = 5'd7; end
      // q = s x e1
      5'd12: begin opa = 66'(ev[7]); opb = ev[2]; end
      5'd13: begin opa = 66'(ev[8]); opb = ev[1]; dst = 5'd3; end
      5'd14: begin opa = 66'(ev[8]); opb = ev[0]; end
      5'd15: begin opa = 66'(ev[6]); opb = ev[2]; dst = 5'd4; end
      5'd16: begin opa = 66'(ev[6]); opb = ev[1]; end
      5'd17: begin opa = 66'(ev[7]); opb = ev[0]; dst = 5'd5; end
      // v = d.q, t = e2.q
      5'd18: begin opa = pq[3]; opb = ev[9];  wide = 1'b1; end
      5'd19: begin opa = pq[4]; opb = ev[10]; wide = 1'b1; end
      5'd20: begin opa = pq[5]; opb = ev[11]; wide = 1'b1; dst = 5'd8; end
      5'd21: begin opa = pq[3]; opb = ev[3];  wide = 1'b1; end
      5'd22: begin opa = pq[4]; opb = ev[4];  wide = 1'b1; end
      5'd23: begin opa = pq[5]; opb = ev[5];  wide = 1'b1; dst = 5'd9; end
      default: begin opa = '0; opb = '0; end
    endcase
  end

  // wide operands go through in two halves: low 33 bits unsigned, then high part
  always_comb begin
    if (!wide) ma = 34'(signed'(opa[32:0]));
    else if (cmd.half) ma = 34'(signed'(opa[65:33]));
    else ma = $signed({1'b0, opa[32:0]});
  end

  assign prod = 67'(ma) * 67'(opb);
  assign term = cmd.half ? (DW'(prod) <<< 33) : DW'(prod);
  assign limit = (mode_bits[1] && have_hit) ? best_distance : max_range;

  assign sts.pass = pass;
  assign sts.inrng = inrng;
  assign sts.dbusy = (dcnt != 8'd0);

  logic signed [DW-1:0] acc_sum;
  assign acc_sum = cmd.first ? term : (cmd.sub ? acc - term : acc + term);

  always_ff @(posedge clk) begin
    if (rst) begin
      org[0] <= '0; org[1] <= '0; org[2] <= '0;
      dir[0] <= 32'sd65536; dir[1] <= '0; dir[2] <= '0;
      max_range <= 31'h7FFF_FFFF;
      mode_bits <= '0;
      best_distance <= '0;
      have_hit <= 1'b0;
      dcnt <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ORG_X: org[0] <= cfg_data;
          REG_ORG_Y: org[1] <= cfg_data;
          REG_ORG_Z: org[2] <= cfg_data;
          REG_DIR_X: dir[0] <= cfg_data;
          REG_DIR_Y: dir[1] <= cfg_data;
          REG_DIR_Z: dir[2] <= cfg_data;
          REG_RANGE: max_range <= cfg_data[30:0];
          REG_MODE:  mode_bits <= cfg_data[1:0];
          default: ;
        endcase
      end
      case (cmd.op)
        OP_LOAD: begin
          if (new_query) begin
            have_hit <= 1'b0;
            best_distance <= max_range;
          end
        end
        OP_DIV_T, OP_DIV_U, OP_DIV_V: dcnt <= 8'd128;
        OP_DSTEP: if (dcnt != 8'd0) dcnt <= dcnt - 8'd1;
        OP_FINISH: begin
          if (inrng && mode_bits[1] && (!have_hit || tdist < best_distance)) begin
            best_distance <= tdist;
            have_hit <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        for (int k = 0; k < 3; k++) begin
          ev[k]   <= 33'(signed'(verts[32*(3+k) +: 32])) - 33'(signed'(verts[32*k +: 32]));
          ev[3+k] <= 33'(signed'(verts[32*(6+k) +: 32])) - 33'(signed'(verts[32*k +: 32]));
          ev[6+k] <= 33'(org[k]) - 33'(signed'(verts[32*k +: 32]));
          ev[9+k] <= 33'(dir[k]);
        end
        hit_id <= tri_id;
        hit <= 1'b0;
        new_nearest <= 1'b0;
        hit_distance <= '0;
        u_coord <= '0;
        v_coord <= '0;
        pass <= 1'b0;
        inrng <= 1'b0;
        tdist <= '0;
      end
      OP_MUL, OP_STORE: begin
        acc <= acc_sum;
        if (cmd.op == OP_STORE) begin
          case (dst)
            5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5: pq[dst[2:0]] <= acc_sum[65:0];
            5'd6: det <= acc_sum;
            5'd7: uu <= acc_sum;
            5'd8: vv <= acc_sum;
            5'd9: tt <= acc_sum;
            default: ;
          endcase
        end
      end
      OP_FOLD: begin : fold
        logic signed [DW-1:0] d2, u2, v2, t2;
        logic neg;
        neg = !mode_bits[0] && det[DW-1];
        d2 = neg ? -det : det;
        u2 = neg ? -uu : uu;
        v2 = neg ? -vv : vv;
        t2 = neg ? -tt : tt;
        det <= d2; uu <= u2; vv <= v2; tt <= t2;
        pass <= !(d2 < (DW'(1) <<< EPS_SHIFT)) && !u2[DW-1] && !(d2 < u2) && !v2[DW-1]
                && !(d2 < u2 + v2) && !t2[DW-1] && (t2 != '0);
      end
      OP_DIV_T, OP_DIV_U, OP_DIV_V: begin
        dnum <= (cmd.op == OP_DIV_T) ? (tt <<< FRAC_BITS) :
                (cmd.op == OP_DIV_U) ? (uu <<< UV_BITS) : (vv <<< UV_BITS);
        dden <= det;
        drem <= '0;
        dquo <= '0;
      end
      OP_DSTEP: begin : dstep
        logic [DW:0] r2;
        if (dcnt != 8'd0) begin
          r2 = {drem, dnum[DW-1]};
          dnum <= dnum << 1;
          if (r2 >= {1'b0, dden}) begin
            drem <= DW'(r2 - {1'b0, dden});
            dquo <= {dquo[DW-2:0], 1'b1};
          end else begin
            drem <= r2[DW-1:0];
            dquo <= {dquo[DW-2:0], 1'b0};
          end
        end
      end
      OP_DDONE: begin
        tdist <= dquo[30:0];
        inrng <= (dquo != '0) && (dquo <= DW'(limit));
      end
      OP_FINISH: begin
        if (inrng) begin
          hit <= 1'b1;
          hit_distance <= tdist;
          u_coord <= u_coord;
          new_nearest <= mode_bits[1] && (!have_hit || tdist < best_distance);
        end
      end
      default: ;
    endcase
    // u quotient lands when v starts; v when finish comes
    if (cmd.op == OP_DIV_V) u_coord <= dquo[16:0];
    if (cmd.op == OP_FINISH && inrng) v_coord <= dquo[16:0];
  end
endmodule
`default_nettype wire

// File: hdl/ray_triangle_nearest_hit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ray_triangle_nearest_hit: Moller-Trumbore ray/triangle test, nearest record
// One triangle word in, one result word out; a sequencer drives a datapath.
// ----------------------------------------------------------------------------
// Sequence: a triangle that fails the geometric tests goes from the product program
//   and the fold straight to its result; one out of range also runs the t divide, and
//   a hit runs t, u and v (product program on one 34x33 multiplier, 128-step divides).
// Flow: one triangle at a time; the next word is taken the cycle after the
//   result word leaves.
// Reset: rst is synchronous; registers return to origin 0, direction +x,
//   range max, plain mode; nearest record cleared.
module ray_triangle_nearest_hit (
  input wire      clk,
  input wire      rst,
  rtnh_cfg_if.sink   cfg,
  rtnh_tri_if.sink   tri_in,
  rtnh_res_if.source res
);
  import rtnh_pkg::*;

  rtnh_cmd_t cmd;
  rtnh_sts_t sts;

  // register writes are always taken; callers write only while idle
  assign cfg.ready = 1'b1;

  rtnh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (tri_in.valid),
    .in_ready (tri_in.ready),
    .out_valid(res.valid),
    .out_ready(res.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rtnh_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_we      (cfg.valid),
    .cfg_index   (cfg.index),
    .cfg_data    (cfg.data),
    .verts       ({tri_in.vert2_z, tri_in.vert2_y, tri_in.vert2_x,
                   tri_in.vert1_z, tri_in.vert1_y, tri_in.vert1_x,
                   tri_in.vert0_z, tri_in.vert0_y, tri_in.vert0_x}),
    .tri_id      (tri_in.tri_id),
    .new_query   (tri_in.new_query),
    .hit         (res.hit),
    .hit_distance(res.hit_distance),
    .u_coord     (res.u_coord),
    .v_coord     (res.v_coord),
    .hit_id      (res.hit_id),
    .new_nearest (res.new_nearest)
  );
endmodule
`default_nettype wire
